/* hdl/clr_pkg.sv */
// Shared types, constants and helper functions for the clipped line rasterizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package clr_pkg;

   localparam int CW = 17;          // coordinate width, signed
   localparam int PW = 2 * CW;      // product width
   localparam int IN_W = 16;        // input coordinate width
   localparam int PIX_W = 8;
   localparam int VIEW_W = 9;
   localparam int STRIDE_W = 11;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VIEW_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_STRIDE  = 2'd2;

   localparam logic [3:0] OC_TOP    = 4'h1;
   localparam logic [3:0] OC_BOTTOM = 4'h2;
   localparam logic [3:0] OC_LEFT   = 4'h4;
   localparam logic [3:0] OC_RIGHT  = 4'h8;

   localparam logic ACTION_DRAW = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   typedef enum logic [2:0] {
      RULE_NONE,
      RULE_TOP,
      RULE_BOTTOM,
      RULE_LEFT,
      RULE_RIGHT
   } clip_rule_type;

   function automatic logic [3:0] outcode(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                          logic signed [CW-1:0] w, logic signed [CW-1:0] h);
      logic [3:0] c;
      c = 4'h0;
      if (y < 0) c = c | OC_TOP;
      if (y > h - CW'(1)) c = c | OC_BOTTOM;
      if (x < 0) c = c | OC_LEFT;
      if (x > w - CW'(1)) c = c | OC_RIGHT;
      return c;
   endfunction

   function automatic clip_rule_type clip_rule(logic [3:0] code);
      clip_rule_type r;
      if (code == OC_TOP || code == (OC_TOP | OC_RIGHT)) r = RULE_TOP;
      else if (code == OC_BOTTOM || code == (OC_BOTTOM | OC_LEFT)) r = RULE_BOTTOM;
      else if (code == OC_LEFT || code == (OC_LEFT | OC_TOP)) r = RULE_LEFT;
      else if (code == OC_RIGHT || code == (OC_RIGHT | OC_BOTTOM)) r = RULE_RIGHT;
      else r = RULE_NONE;
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/clr_if.sv */
// Valid/ready channel interfaces for commands and results.
// Depends on clr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface clr_req_if;
   logic                                valid;
   logic                                ready;
   logic                                action;
   logic signed [clr_pkg::IN_W-1:0]     start_x;
   logic signed [clr_pkg::IN_W-1:0]     start_y;
   logic signed [clr_pkg::IN_W-1:0]     end_x;
   logic signed [clr_pkg::IN_W-1:0]     end_y;
   logic        [clr_pkg::PIX_W-1:0]    pen_color;

   modport source (output valid, action, start_x, start_y, end_x, end_y, pen_color,
                   input ready);
   modport sink   (input valid, action, start_x, start_y, end_x, end_y, pen_color,
                   output ready);
endinterface

interface clr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             drawn;
   logic [clr_pkg::PIX_W-1:0]        pixel_value;

   modport source (output valid, drawn, pixel_value, input ready);
   modport sink   (input valid, drawn, pixel_value, output ready);
endinterface

`default_nettype wire

/* hdl/clr_divider.sv */
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
// Zero divisor gives a zero quotient. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module clr_divider #(
   parameter int NW = 34,
   parameter int DW = 17
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [NW-1:0] num,
   input  wire logic signed [DW-1:0] den,
   output logic                      done,
   output logic signed [NW-1:0]      quo
);

   localparam int CNT_W = $clog2(NW + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DW-1:0]    rem_ff;
   logic [NW-1:0]    q_ff;
   logic [DW-1:0]    dmag_ff;
   logic             neg_ff;
   logic             zero_ff;

   logic [DW:0]      rsh;
   logic             fit;

   assign rsh = {rem_ff, q_ff[NW-1]};
   assign fit = rsh >= {1'b0, dmag_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NW);
            rem_ff  <= '0;
            q_ff    <= num[NW-1] ? NW'(-num) : NW'(num);
            dmag_ff <= den[DW-1] ? DW'(-den) : DW'(den);
            neg_ff  <= num[NW-1] ^ den[DW-1];
            zero_ff <= (den == '0);
         end else if (busy_ff) begin
            rem_ff <= fit ? DW'(rsh - {1'b0, dmag_ff}) : rsh[DW-1:0];
            q_ff   <= {q_ff[NW-2:0], fit};
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = zero_ff ? '0 : (neg_ff ? -$signed(q_ff) : $signed(q_ff));

endmodule

`default_nettype wire

/* hdl/clipped_line_rasterizer.sv */
// Clipped line rasterizer top level: frame store, clipping sequencer, line stepper.
// Depends on clr_pkg, clr_if, clr_divider.
//
// Usage: commands arrive on req_chan (valid/ready), one result per command leaves
// on rsp_chan. A draw command clips the line with outcodes (each clip step takes
// one multiply and a divide), then writes one pixel per cycle into the frame store.
// One command is in flight at a time; the frame store's single write port sets
// the drawing rate.
// After reset the frame store is cleared, one byte per cycle; req_chan.ready stays
// low meanwhile. csr writes are taken at any time but must only change registers
// while the block is idle.
// The result sits in an output register; a stalled receiver holds the block only
// when a second result is ready before the first is taken.
`timescale 1ns / 1ps
`default_nettype none

module clipped_line_rasterizer #(
   parameter int STORE_BYTES = 65536,
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_HEIGHT  = 256
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   clr_req_if.sink                                req_chan,
   clr_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [clr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [clr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CW  = clr_pkg::CW;
   localparam int PW  = clr_pkg::PW;
   localparam int AW  = $clog2(STORE_BYTES);
   localparam int AFW = clr_pkg::IN_W + clr_pkg::STRIDE_W + 1;
   localparam int NW  = 5;
   localparam logic [NW-1:0] CLIP_STEPS = 5'd16;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_CLIP, S_MUL, S_DIVS, S_DIVW,
      S_SETUP, S_DRAW, S_FLUSH, S_RADDR, S_RDATA, S_RESP
   } state_type;

   state_type state_ff;

   logic [clr_pkg::VIEW_W-1:0]   view_width_ff;
   logic [clr_pkg::VIEW_W-1:0]   view_height_ff;
   logic [clr_pkg::STRIDE_W-1:0] row_stride_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_width_ff  <= 9'd256;
         view_height_ff <= 9'd256;
         row_stride_ff  <= 11'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            clr_pkg::CSR_VIEW_WIDTH:  view_width_ff  <= csr_wdata[clr_pkg::VIEW_W-1:0];
            clr_pkg::CSR_VIEW_HEIGHT: view_height_ff <= csr_wdata[clr_pkg::VIEW_W-1:0];
            clr_pkg::CSR_ROW_STRIDE:  row_stride_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // frame store
   logic [clr_pkg::PIX_W-1:0] mem [STORE_BYTES];
   logic                      we_ff;
   logic [AW-1:0]             wa_ff;
   logic [clr_pkg::PIX_W-1:0] wd_ff;
   logic                      rd_en;
   logic [AW-1:0]             ra;
   logic [clr_pkg::PIX_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we_ff) mem[wa_ff] <= wd_ff;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rdata_ff <= mem[ra];
   end

   // command registers
   logic signed [CW-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic [clr_pkg::PIX_W-1:0] color_ff;
   logic [NW-1:0] n_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic          use_end_ff;
   clr_pkg::clip_rule_type rule_ff;
   logic signed [CW-1:0] ma_ff, mb_ff, den_ff;
   logic signed [PW-1:0] prod_ff;

   // line stepper registers
   logic signed [CW-1:0] x_ff, y_ff, full_ff, minor_ff, half_ff, i_ff;
   logic                 inc_neg_ff, steep_ff;

   // result registers
   logic                      rsp_valid_ff;
   logic                      rsp_drawn_ff;
   logic [clr_pkg::PIX_W-1:0] rsp_pix_ff;
   logic                      res_drawn_ff;
   logic [clr_pkg::PIX_W-1:0] res_pix_ff;
   logic                      rd_ok_ff;

   // window
   logic signed [CW-1:0] w_s, h_s;
   assign w_s = (view_width_ff > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(view_width_ff);
   assign h_s = (view_height_ff > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(view_height_ff);

   // clip decision
   logic [3:0] c1, c2;
   clr_pkg::clip_rule_type r1, r2, rsel;
   logic use_end;
   logic signed [CW-1:0] px, py, ox, oy;
   logic signed [CW-1:0] ma_in, mb_in, den_in;

   always_comb begin
      c1 = clr_pkg::outcode(sx_ff, sy_ff, w_s, h_s);
      c2 = clr_pkg::outcode(ex_ff, ey_ff, w_s, h_s);
      r1 = clr_pkg::clip_rule(c1);
      r2 = clr_pkg::clip_rule(c2);
      use_end = (c1 == 4'h0) || (r1 == clr_pkg::RULE_NONE);
      rsel = use_end ? r2 : r1;
      px = use_end ? ex_ff : sx_ff;
      py = use_end ? ey_ff : sy_ff;
      ox = use_end ? sx_ff : ex_ff;
      oy = use_end ? sy_ff : ey_ff;
      unique case (rsel)
         clr_pkg::RULE_TOP: begin
            ma_in = ox - px; mb_in = -py; den_in = oy - py;
         end
         clr_pkg::RULE_BOTTOM: begin
            ma_in = ox - px; mb_in = py - (h_s - CW'(1)); den_in = py - oy;
         end
         clr_pkg::RULE_LEFT: begin
            ma_in = oy - py; mb_in = -px; den_in = ox - px;
         end
         clr_pkg::RULE_RIGHT: begin
            ma_in = oy - py; mb_in = px - (w_s - CW'(1)); den_in = px - ox;
         end
         default: begin
            ma_in = '0; mb_in = '0; den_in = '0;
         end
      endcase
   end

   // divider
   logic                 div_done;
   logic signed [PW-1:0] div_quo;
   logic signed [CW-1:0] q_s;
   logic signed [CW-1:0] npx, npy;

   clr_divider #(.NW(PW), .DW(CW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_DIVS),
      .num   (prod_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign q_s = div_quo[CW-1:0];

   always_comb begin
      npx = use_end_ff ? ex_ff : sx_ff;
      npy = use_end_ff ? ey_ff : sy_ff;
      unique case (rule_ff)
         clr_pkg::RULE_TOP:    begin npx = npx + q_s; npy = '0; end
         clr_pkg::RULE_BOTTOM: begin npx = npx + q_s; npy = h_s - CW'(1); end
         clr_pkg::RULE_LEFT:   begin npy = npy + q_s; npx = '0; end
         clr_pkg::RULE_RIGHT:  begin npy = npy + q_s; npx = w_s - CW'(1); end
         default: ;
      endcase
   end

   // line setup
   logic                 swap;
   logic signed [CW-1:0] lx0, ly0, lx1, ly1, ldx, ldy, ladx;
   logic                 lsteep;

   always_comb begin
      swap   = ey_ff < sy_ff;
      lx0    = swap ? ex_ff : sx_ff;
      ly0    = swap ? ey_ff : sy_ff;
      lx1    = swap ? sx_ff : ex_ff;
      ly1    = swap ? sy_ff : ey_ff;
      ldx    = lx1 - lx0;
      ldy    = ly1 - ly0;
      ladx   = ldx[CW-1] ? -ldx : ldx;
      lsteep = ladx < ldy;
   end

   // line step
   logic signed [CW-1:0] h2, xinc;
   assign h2   = half_ff - minor_ff;
   assign xinc = inc_neg_ff ? -CW'(1) : CW'(1);

   // shared address multiply
   logic signed [CW-1:0] ax, ay;
   logic [AFW-1:0]       addr_full;
   logic                 addr_ok;

   assign ax = (state_ff == S_DRAW) ? x_ff : sx_ff;
   assign ay = (state_ff == S_DRAW) ? y_ff : sy_ff;
   assign addr_full = AFW'(ay[CW-2:0]) * AFW'(row_stride_ff) + AFW'(ax[CW-2:0]);
   assign addr_ok = !ax[CW-1] && !ay[CW-1] && (addr_full < AFW'(STORE_BYTES));
   assign rd_en = (state_ff == S_RADDR) && addr_ok;
   assign ra = addr_full[AW-1:0];

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.drawn       = rsp_drawn_ff;
   assign rsp_chan.pixel_value = rsp_pix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         we_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) rsp_valid_ff <= 1'b0;
         we_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               we_ff      <= 1'b1;
               wa_ff      <= clr_cnt_ff;
               wd_ff      <= '0;
               clr_cnt_ff <= clr_cnt_ff + AW'(1);
               if (clr_cnt_ff == AW'(STORE_BYTES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_chan.valid) begin
                  sx_ff    <= CW'(req_chan.start_x);
                  sy_ff    <= CW'(req_chan.start_y);
                  ex_ff    <= CW'(req_chan.end_x);
                  ey_ff    <= CW'(req_chan.end_y);
                  color_ff <= req_chan.pen_color;
                  n_ff     <= '0;
                  state_ff <= (req_chan.action == clr_pkg::ACTION_READ) ? S_RADDR : S_CLIP;
               end
            end
            S_CLIP: begin
               if (w_s == '0 || h_s == '0) begin
                  res_drawn_ff <= 1'b0;
                  res_pix_ff   <= '0;
                  state_ff     <= S_RESP;
               end else if (c1 == 4'h0 && c2 == 4'h0) begin
                  state_ff <= S_SETUP;
               end else if ((c1 & c2) != 4'h0 || n_ff >= CLIP_STEPS) begin
                  res_drawn_ff <= 1'b0;
                  res_pix_ff   <= '0;
                  state_ff     <= S_RESP;
               end else if (rsel == clr_pkg::RULE_NONE) begin
                  n_ff <= n_ff + NW'(1);
               end else begin
                  use_end_ff <= use_end;
                  rule_ff    <= rsel;
                  ma_ff      <= ma_in;
                  mb_ff      <= mb_in;
                  den_ff     <= den_in;
                  state_ff   <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= PW'(ma_ff) * PW'(mb_ff);
               state_ff <= S_DIVS;
            end
            S_DIVS: state_ff <= S_DIVW;
            S_DIVW: begin
               if (div_done) begin
                  if (use_end_ff) begin
                     ex_ff <= npx;
                     ey_ff <= npy;
                  end else begin
                     sx_ff <= npx;
                     sy_ff <= npy;
                  end
                  n_ff     <= n_ff + NW'(1);
                  state_ff <= S_CLIP;
               end
            end
            S_SETUP: begin
               x_ff       <= lx0;
               y_ff       <= ly0;
               inc_neg_ff <= ldx[CW-1];
               steep_ff   <= lsteep;
               full_ff    <= lsteep ? ldy : ladx;
               minor_ff   <= lsteep ? ladx : ldy;
               half_ff    <= (lsteep ? ldy : ladx) >>> 1;
               i_ff       <= '0;
               state_ff   <= S_DRAW;
            end
            S_DRAW: begin
               we_ff <= addr_ok;
               wa_ff <= addr_full[AW-1:0];
               wd_ff <= color_ff;
               if (i_ff == full_ff) begin
                  state_ff <= S_FLUSH;
               end else begin
                  i_ff <= i_ff + CW'(1);
                  if (steep_ff) begin
                     y_ff <= y_ff + CW'(1);
                     if (h2 < 0) x_ff <= x_ff + xinc;
                  end else begin
                     x_ff <= x_ff + xinc;
                     if (h2 < 0) y_ff <= y_ff + CW'(1);
                  end
                  half_ff <= (h2 < 0) ? h2 + full_ff : h2;
               end
            end
            S_FLUSH: begin
               res_drawn_ff <= 1'b1;
               res_pix_ff   <= '0;
               state_ff     <= S_RESP;
            end
            S_RADDR: begin
               rd_ok_ff <= addr_ok;
               state_ff <= S_RDATA;
            end
            S_RDATA: begin
               res_drawn_ff <= 1'b0;
               res_pix_ff   <= rd_ok_ff ? rdata_ff : '0;
               state_ff     <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_drawn_ff <= res_drawn_ff;
                  rsp_pix_ff   <= res_pix_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_draw_x_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAW) |-> (x_ff >= 0 && x_ff < w_s))
      else $error("line stepper left the window in x");

   a_draw_y_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAW) |-> (y_ff >= 0 && y_ff < h_s))
      else $error("line stepper left the window in y");

   a_clip_bound: assert property (@(posedge clock) disable iff (reset)
      (n_ff <= CLIP_STEPS))
      else $error("clip step count overran");

   a_no_write_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |-> !we_ff)
      else $error("store write while a result is pending");

endmodule

`default_nettype wire
